// ===== src/swlm_pkg.sv =====
// Shared constants, types and helpers of the sliding-window local maxima core.
package swlm_pkg;

  localparam int DATA_W            = 32;
  localparam int POS_W             = 16;
  localparam int HALF_W            = 5;
  localparam int MAX_HALF_WINDOW   = 31;
  localparam int HALF_WINDOW_RESET = 3;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic {
    REG_HALF_WINDOW = 1'b0
  } reg_idx_e;

  // One decision as it leaves the core.
  typedef struct packed {
    logic             is_peak;
    logic [POS_W-1:0] position;
    logic             last_result;
  } result_t;

  // Status of the result stage as seen by the input control.
  typedef struct packed {
    logic busy;   // a sequence-end flush is still draining
    logic free;   // the output register can take a result this cycle
  } outq_status_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    sat_inc = (v == POS_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== src/swlm_cell.sv =====
// One window cell: holds a sample and its neighbor comparison flags, decides its age slot.
module swlm_cell #(
  parameter int MaxHalfWindow = swlm_pkg::MAX_HALF_WINDOW,
  parameter int Age           = 0,
  localparam int AW           = $clog2(MaxHalfWindow + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  logic                               clear_i,
  input  logic signed [swlm_pkg::DATA_W-1:0] sample_i,
  input  logic        [AW-1:0]               half_i,
  input  logic signed [swlm_pkg::DATA_W-1:0] prev_value_i,
  input  logic        [MaxHalfWindow-1:0]    prev_newer_i,
  input  logic        [MaxHalfWindow-1:0]    prev_older_i,
  output logic signed [swlm_pkg::DATA_W-1:0] value_o,
  output logic        [MaxHalfWindow-1:0]    newer_o,
  output logic        [MaxHalfWindow-1:0]    older_o,
  output logic                               ge_o,
  output logic                               peak_o
);

  logic signed [swlm_pkg::DATA_W-1:0] value_q;
  logic        [MaxHalfWindow-1:0]    newer_q, older_q;
  logic        [MaxHalfWindow-1:0]    newer_post, mask_new, mask_old;
  logic                               ge, pad_ok;

  // Bit d-1 of the flag vectors belongs to the neighbor at distance d.
  always_comb begin
    ge = (Age == 0) ? 1'b1 : (prev_value_i >= sample_i);
    for (int d = 0; d < MaxHalfWindow; d++) begin
      newer_post[d] = (d == Age - 1) ? ge : prev_newer_i[d];
      mask_old[d]   = (d + 1 <= int'(half_i));
      mask_new[d]   = (d + 1 <= int'(half_i)) && (d + 1 <= Age);
    end
    // Newer neighbors past the end of the sequence are zero padding.
    pad_ok = (Age >= int'(half_i)) || !prev_value_i[swlm_pkg::DATA_W-1];
    peak_o = (&(newer_post | ~mask_new)) && (&(prev_older_i | ~mask_old)) && pad_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      newer_q <= '0;
      older_q <= '0;
    end else if (shift_i) begin
      if (clear_i) begin
        value_q <= '0;
        newer_q <= '0;
        older_q <= '0;
      end else begin
        value_q <= prev_value_i;
        newer_q <= newer_post;
        older_q <= prev_older_i;
      end
    end
  end

  assign value_o = value_q;
  assign newer_o = newer_q;
  assign older_o = older_q;
  assign ge_o    = ge;

endmodule

// ===== src/swlm_outq.sv =====
// Result stage: output register plus the engine that drains a sequence-end flush.
module swlm_outq #(
  parameter int MaxHalfWindow = swlm_pkg::MAX_HALF_WINDOW,
  localparam int NCELL        = MaxHalfWindow + 1,
  localparam int AW           = $clog2(NCELL)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  swlm_pkg::result_t            push_res_i,
  input  logic                         load_i,
  input  logic [NCELL-1:0]             load_bits_i,
  input  logic [AW-1:0]                load_first_i,
  input  logic [swlm_pkg::POS_W-1:0]   load_pos_i,
  input  logic                         m_ready_i,
  output logic                         m_valid_o,
  output swlm_pkg::result_t            m_res_o,
  output swlm_pkg::outq_status_t       status_o
);

  logic                       fact_q;
  logic [NCELL-1:0]           fbits_q;
  logic [AW-1:0]              fidx_q;
  logic [swlm_pkg::POS_W-1:0] fpos_q;
  logic                       oval_q;
  swlm_pkg::result_t          ores_q;
  logic                       free;

  assign free = !oval_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fact_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      if (load_i) begin
        fact_q <= 1'b1;
      end else if (fact_q && free && (fidx_q == '0)) begin
        fact_q <= 1'b0;
      end
      if (free) begin
        oval_q <= fact_q || push_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fbits_q <= load_bits_i;
      fidx_q  <= load_first_i;
      fpos_q  <= load_pos_i;
    end else if (fact_q && free) begin
      fidx_q <= fidx_q - 1'b1;
      fpos_q <= swlm_pkg::sat_inc(fpos_q);
    end
    if (free) begin
      if (fact_q) begin
        ores_q.is_peak     <= fbits_q[fidx_q];
        ores_q.position    <= fpos_q;
        ores_q.last_result <= (fidx_q == '0);
      end else begin
        ores_q <= push_res_i;
      end
    end
  end

  assign m_valid_o     = oval_q;
  assign m_res_o       = ores_q;
  assign status_o.busy = fact_q;
  assign status_o.free = free;

endmodule

// ===== src/sliding_window_local_maxima_core.sv =====
// Top level of the sliding-window local maxima detector.
//
// Samples enter on the s_ channel, one signed 32-bit value per beat, with
// s_tlast on the final sample of a sequence. Each decided sample leaves on
// the m_ channel: m_tdata is its position in the sequence (saturating at
// 65535), m_tuser is the peak flag and m_tlast marks the final decision.
// A sample is a peak when it beats the h samples before it strictly and the
// h samples after it or ties them, with zeros past both ends of a sequence.
// half_window (h) is written over the APB port; the user must do so only while
// the core is idle, which the core does not enforce. Throughput is one sample
// per cycle while s_tready is high: every window cell compares its sample with
// the incoming one in the same cycle. In mid-sequence a decision appears h
// samples after its sample, in the cycle after the beat that decides it. A
// final sample of an n-sample sequence triggers a flush of min(h, n-1)+1
// decisions, one per cycle unless the receiver stalls; s_tready stays low until
// the flush has drained. If the receiver stalls, the output register holds its
// beat and s_tready drops, so nothing is lost. Reset clears the window to zeros,
// the counters to zero and sets half_window to 3; no clearing pass is needed.
module sliding_window_local_maxima_core #(
  parameter int MaxHalfWindow = swlm_pkg::MAX_HALF_WINDOW
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample stream; tdata: sample_value[31:0]; tlast: last_sample.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  // Decision stream; tdata: position[15:0]; tuser: is_peak; tlast: last_result.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NCELL = MaxHalfWindow + 1;
  localparam int AW    = $clog2(NCELL);
  localparam int PW    = swlm_pkg::POS_W;
  localparam int DW    = swlm_pkg::DATA_W;

  logic [swlm_pkg::HALF_W-1:0] half_q;
  logic [PW-1:0]               seen_q, npos_q;
  logic [PW-1:0]               seen_post, seen_m1, first_w;
  logic [AW-1:0]               h_eff;
  logic                        acc, emit_now;
  logic signed [DW-1:0]        sample;

  logic signed [DW-1:0]        cval [NCELL-2:0];
  logic [MaxHalfWindow-1:0]    cnew [NCELL-2:0];
  logic [MaxHalfWindow-1:0]    cold [NCELL-2:0];
  logic [MaxHalfWindow-1:0]    ge;
  logic [NCELL-1:0]            dec;

  swlm_pkg::result_t           push_res, out_res;
  swlm_pkg::outq_status_t      oq_status;

  // Configuration register. Writes complete in the APB access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= swlm_pkg::HALF_W'(swlm_pkg::HALF_WINDOW_RESET);
    end else if (psel && penable && pwrite &&
                 (paddr[2] == swlm_pkg::REG_HALF_WINDOW)) begin
      half_q <= pwdata[swlm_pkg::HALF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == swlm_pkg::REG_HALF_WINDOW) begin
      prdata = 32'(half_q);
    end
  end

  // A half window larger than MaxHalfWindow, one less than the cell count, is clamped to it.
  always_comb begin
    if (int'(half_q) > MaxHalfWindow) begin
      h_eff = AW'(MaxHalfWindow);
    end else begin
      h_eff = AW'(half_q);
    end
  end

  assign sample   = $signed(s_tdata);
  assign s_tready = !oq_status.busy && oq_status.free;
  assign acc      = s_tvalid && s_tready;

  // Sequence bookkeeping; both counters saturate.
  assign seen_post = swlm_pkg::sat_inc(seen_q);
  assign seen_m1   = seen_post - 1'b1;
  assign first_w   = (PW'(h_eff) > seen_m1) ? seen_m1 : PW'(h_eff);
  assign emit_now  = acc && !s_tlast && (PW'(h_eff) < seen_post);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      npos_q <= '0;
    end else if (acc) begin
      if (s_tlast) begin
        seen_q <= '0;
        npos_q <= '0;
      end else begin
        seen_q <= seen_post;
        if (emit_now) begin
          npos_q <= swlm_pkg::sat_inc(npos_q);
        end
      end
    end
  end

  // Cell row. Cell g decides the sample that sits at age g once the current
  // beat has been shifted in. The head cell takes the new sample; its
  // older-neighbor flags come from every other cell's compare.
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == 0) begin : g_head
      swlm_cell #(.MaxHalfWindow(MaxHalfWindow), .Age(g)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (acc),
        .clear_i      (s_tlast),
        .sample_i     (sample),
        .half_i       (h_eff),
        .prev_value_i (sample),
        .prev_newer_i ('0),
        .prev_older_i (~ge),
        .value_o      (cval[g]),
        .newer_o      (cnew[g]),
        .older_o      (cold[g]),
        .ge_o         (),
        .peak_o       (dec[g])
      );
    end else if (g == NCELL - 1) begin : g_tail
      swlm_cell #(.MaxHalfWindow(MaxHalfWindow), .Age(g)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (acc),
        .clear_i      (s_tlast),
        .sample_i     (sample),
        .half_i       (h_eff),
        .prev_value_i (cval[g-1]),
        .prev_newer_i (cnew[g-1]),
        .prev_older_i (cold[g-1]),
        .value_o      (),
        .newer_o      (),
        .older_o      (),
        .ge_o         (ge[g-1]),
        .peak_o       (dec[g])
      );
    end else begin : g_mid
      swlm_cell #(.MaxHalfWindow(MaxHalfWindow), .Age(g)) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .shift_i      (acc),
        .clear_i      (s_tlast),
        .sample_i     (sample),
        .half_i       (h_eff),
        .prev_value_i (cval[g-1]),
        .prev_newer_i (cnew[g-1]),
        .prev_older_i (cold[g-1]),
        .value_o      (cval[g]),
        .newer_o      (cnew[g]),
        .older_o      (cold[g]),
        .ge_o         (ge[g-1]),
        .peak_o       (dec[g])
      );
    end
  end

  // In mid-sequence the one decision is the sample at age h.
  assign push_res.is_peak     = dec[h_eff];
  assign push_res.position    = npos_q;
  assign push_res.last_result = 1'b0;

  swlm_outq #(.MaxHalfWindow(MaxHalfWindow)) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (emit_now),
    .push_res_i   (push_res),
    .load_i       (acc && s_tlast),
    .load_bits_i  (dec),
    .load_first_i (AW'(first_w)),
    .load_pos_i   (npos_q),
    .m_ready_i    (m_tready),
    .m_valid_o    (m_tvalid),
    .m_res_o      (out_res),
    .status_o     (oq_status)
  );

  assign m_tdata    = out_res.position;
  assign m_tuser[0] = out_res.is_peak;
  assign m_tlast    = out_res.last_result;

`ifndef SYNTHESIS
  // A final sample always starts a flush.
  a_last_starts_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_tlast |=> oq_status.busy)
    else $error("final sample did not start a flush");

  // The final decision is only shown once the flush has drained.
  a_flush_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tlast |-> !oq_status.busy)
    else $error("final decision shown while the flush is still running");

  // A sequence end resets the counters for the next sequence.
  a_counters_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_tlast |=> (seen_q == '0) && (npos_q == '0))
    else $error("counters not cleared after a sequence end");

  // The window returns to zero padding after a sequence end.
  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_tlast |=> (cval[0] == '0))
    else $error("window not cleared after a sequence end");
`endif

endmodule
